// ----- design/blrd_pkg.sv -----
// Shared constants, codes and types of the block log record deframer.
package blrd_pkg;

    // Log file layout.
    localparam int BLOCK_BYTES  = 65536;
    localparam int HEADER_BYTES = 8;

    // Block position runs 0 .. BLOCK_BYTES-1; the space left needs one bit more.
    localparam int POS_W     = $clog2(BLOCK_BYTES) + 1;
    localparam int HDR_CNT_W = $clog2(HEADER_BYTES);
    localparam int PAD_W     = $clog2(HEADER_BYTES);
    localparam int LEN_W     = 24;
    localparam int FILE_W    = 32;
    localparam int TYPE_W    = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Input actions.
    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_EOF    = 2'd1,
        ACT_ROLL   = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_PAYLOAD  = 3'd0,
        ST_EOF      = 3'd1,
        ST_BAD      = 3'd2,
        ST_OLD      = 3'd3,
        ST_UNKNOWN  = 3'd4
    } status_t;

    // Fragment kinds.
    typedef enum logic [1:0] {
        FRAG_FULL   = 2'd0,
        FRAG_FIRST  = 2'd1,
        FRAG_MIDDLE = 2'd2,
        FRAG_LAST   = 2'd3
    } frag_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FILE = 3'd0,
        CFG_ZERO_TYPE  = 3'd1,
        CFG_FULL_TYPE  = 3'd2,
        CFG_FIRST_TYPE = 3'd3,
        CFG_MIDDLE_TYPE = 3'd4,
        CFG_LAST_TYPE  = 3'd5
    } cfg_idx_t;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_PADDING,
        PH_HALTED
    } phase_t;

    // Restart request from the configuration registers.
    typedef struct packed {
        logic              restart;
        logic [FILE_W-1:0] start_file;
    } cfg_ctl_t;

    // Classification of a header type byte.
    typedef struct packed {
        logic  zero_hit;
        logic  known;
        frag_t kind;
    } type_class_t;

endpackage

// ----- design/blrd_if.sv -----
// Channel interfaces: log bytes in and decoded records out.
interface blrd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface blrd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [1:0]  fragment_kind;
    logic        fragment_end;
    logic        message_end;
    logic [31:0] file_number;
    logic [31:0] record_end_offset;
    logic [2:0]  status;

    modport source (
        output valid, output payload_byte, output fragment_kind, output fragment_end,
        output message_end, output file_number, output record_end_offset,
        output status, input ready
    );
    modport sink (
        input valid, input payload_byte, input fragment_kind, input fragment_end,
        input message_end, input file_number, input record_end_offset,
        input status, output ready
    );
endinterface

// ----- design/blrd_cfg.sv -----
// Configuration registers and header type classification.
module blrd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [blrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [blrd_pkg::CFG_W-1:0]          cfg_data,
    input  logic [blrd_pkg::TYPE_W-1:0]         type_byte,
    output blrd_pkg::cfg_ctl_t                  ctl,
    output blrd_pkg::type_class_t               tclass
);

    logic [blrd_pkg::TYPE_W-1:0] zero_code_reg;
    logic [blrd_pkg::TYPE_W-1:0] full_code_reg;
    logic [blrd_pkg::TYPE_W-1:0] first_code_reg;
    logic [blrd_pkg::TYPE_W-1:0] middle_code_reg;
    logic [blrd_pkg::TYPE_W-1:0] last_code_reg;

    // Type code registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_code_reg   <= 8'd0;
            full_code_reg   <= 8'd1;
            first_code_reg  <= 8'd2;
            middle_code_reg <= 8'd3;
            last_code_reg   <= 8'd4;
        end
        else if (cfg_write)
        begin
            unique case (blrd_pkg::cfg_idx_t'(cfg_index))
                blrd_pkg::CFG_ZERO_TYPE:   zero_code_reg   <= cfg_data[blrd_pkg::TYPE_W-1:0];
                blrd_pkg::CFG_FULL_TYPE:   full_code_reg   <= cfg_data[blrd_pkg::TYPE_W-1:0];
                blrd_pkg::CFG_FIRST_TYPE:  first_code_reg  <= cfg_data[blrd_pkg::TYPE_W-1:0];
                blrd_pkg::CFG_MIDDLE_TYPE: middle_code_reg <= cfg_data[blrd_pkg::TYPE_W-1:0];
                blrd_pkg::CFG_LAST_TYPE:   last_code_reg   <= cfg_data[blrd_pkg::TYPE_W-1:0];
                default:                   ;
            endcase
        end
    end

    // A write of the start file number restarts reading in that file.
    assign ctl.restart    = cfg_write &&
                            (cfg_index == blrd_pkg::CFG_IDX_W'(blrd_pkg::CFG_START_FILE));
    assign ctl.start_file = cfg_data[blrd_pkg::FILE_W-1:0];

    // Priority match: zero type first, then full, first, middle and last.
    always_comb
    begin
        tclass.zero_hit = (type_byte == zero_code_reg);
        tclass.known    = 1'b1;
        tclass.kind     = blrd_pkg::FRAG_FULL;
        if (type_byte == full_code_reg)
        begin
            tclass.kind = blrd_pkg::FRAG_FULL;
        end
        else if (type_byte == first_code_reg)
        begin
            tclass.kind = blrd_pkg::FRAG_FIRST;
        end
        else if (type_byte == middle_code_reg)
        begin
            tclass.kind = blrd_pkg::FRAG_MIDDLE;
        end
        else if (type_byte == last_code_reg)
        begin
            tclass.kind = blrd_pkg::FRAG_LAST;
        end
        else
        begin
            tclass.known = 1'b0;
        end
    end

endmodule

// ----- design/block_log_record_deframer.sv -----
// Top level of the block log record deframer: header parser and result register.
//
//  Channel     Kind         Direction  Carries
//  log_stream  valid/ready  in         action, data_byte
//  records     valid/ready  out        payload byte, fragment marks, file, offset, status
//  cfg_*       write port   in         six configuration registers, index 0..5
//
// Each accepted item is handled as it is taken; its result, if any, appears in the
// output register on the next cycle. One item per cycle is taken while records.ready
// is high or the output register is empty. A stall on records holds the result and
// blocks input until it is taken. Reset is asynchronous, active low, and starts
// at offset zero of file number zero; no clearing pass is needed.
module block_log_record_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    blrd_in_if.sink                         log_stream,
    blrd_out_if.source                      records,
    input  logic                            cfg_write,
    input  logic [blrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blrd_pkg::CFG_W-1:0]      cfg_data
);

    localparam logic [blrd_pkg::POS_W-1:0] BLOCK_END =
        blrd_pkg::POS_W'(blrd_pkg::BLOCK_BYTES);
    localparam logic [blrd_pkg::POS_W-1:0] HDR_SIZE =
        blrd_pkg::POS_W'(blrd_pkg::HEADER_BYTES);
    localparam logic [blrd_pkg::HDR_CNT_W-1:0] HDR_LAST_CNT =
        blrd_pkg::HDR_CNT_W'(blrd_pkg::HEADER_BYTES - 1);

    // Parser state.
    blrd_pkg::phase_t                  phase_reg, phase_next;
    logic [blrd_pkg::POS_W-1:0]        block_pos_reg, block_pos_next;
    logic [blrd_pkg::FILE_W-1:0]       file_pos_reg, file_pos_next;
    logic [blrd_pkg::FILE_W-1:0]       cur_file_reg, cur_file_next;
    logic [blrd_pkg::HDR_CNT_W-1:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [blrd_pkg::LEN_W-1:0]        hdr_len_reg, hdr_len_next;
    logic [blrd_pkg::LEN_W-1:0]        pay_rem_reg, pay_rem_next;
    logic [blrd_pkg::PAD_W-1:0]        pad_rem_reg, pad_rem_next;
    blrd_pkg::frag_t                   kind_reg, kind_next;

    // Result register.
    logic                              res_valid_reg, res_valid_next;
    logic [7:0]                        res_byte_reg, res_byte_next;
    blrd_pkg::frag_t                   res_kind_reg, res_kind_next;
    logic                              res_fend_reg, res_fend_next;
    logic                              res_mend_reg, res_mend_next;
    logic [blrd_pkg::FILE_W-1:0]       res_file_reg, res_file_next;
    logic [blrd_pkg::FILE_W-1:0]       res_off_reg, res_off_next;
    blrd_pkg::status_t                 res_st_reg, res_st_next;

    blrd_pkg::cfg_ctl_t                cfg_ctl;
    blrd_pkg::type_class_t             tclass;

    logic                              accept;
    logic                              halted;
    logic                              take_byte;
    logic                              take_eof;
    logic                              take_roll;
    logic [blrd_pkg::POS_W-1:0]        left;
    logic [blrd_pkg::POS_W-1:0]        pos_inc;
    logic [blrd_pkg::POS_W-1:0]        pos_adv;
    logic [blrd_pkg::POS_W-1:0]        space;
    logic [blrd_pkg::POS_W-1:0]        left_m1;
    logic [blrd_pkg::FILE_W-1:0]       fpos_adv;
    logic                              pad_skip;
    logic                              hdr_last;
    logic                              too_long;
    logic                              old_rec;
    logic                              hdr_err;
    logic                              pay_end;
    logic                              pad_end;
    blrd_pkg::status_t                 err_st;

    blrd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .type_byte (log_stream.data_byte),
        .ctl       (cfg_ctl),
        .tclass    (tclass)
    );

    // Handshake: input flows whenever the result register can take a new value.
    assign log_stream.ready = !res_valid_reg || records.ready;
    assign accept           = log_stream.valid && log_stream.ready;
    assign halted           = (phase_reg == blrd_pkg::PH_HALTED);
    assign take_byte = accept && !halted &&
                       (log_stream.action == blrd_pkg::ACT_BYTE);
    assign take_eof  = accept && !halted &&
                       (log_stream.action == blrd_pkg::ACT_EOF);
    assign take_roll = accept && (log_stream.action == blrd_pkg::ACT_ROLL);

    // Position arithmetic.
    assign left     = BLOCK_END - block_pos_reg;
    assign left_m1  = left - 1'b1;
    assign pos_inc  = block_pos_reg + 1'b1;
    assign pos_adv  = (pos_inc == BLOCK_END) ? '0 : pos_inc;
    assign space    = BLOCK_END - pos_adv;
    assign fpos_adv = file_pos_reg + 1'b1;

    // Header decode.
    assign pad_skip = (phase_reg == blrd_pkg::PH_HEADER) && (hdr_cnt_reg == '0) &&
                      (left <= HDR_SIZE);
    assign hdr_last = (phase_reg == blrd_pkg::PH_HEADER) && (hdr_cnt_reg == HDR_LAST_CNT);
    assign too_long = (hdr_len_reg > blrd_pkg::LEN_W'(space));
    assign old_rec  = tclass.zero_hit || (hdr_len_reg == '0);
    assign hdr_err  = too_long || old_rec || !tclass.known;
    assign err_st   = too_long ? blrd_pkg::ST_BAD :
                      old_rec  ? blrd_pkg::ST_OLD : blrd_pkg::ST_UNKNOWN;
    assign pay_end  = (pay_rem_reg <= blrd_pkg::LEN_W'(1));
    assign pad_end  = (pad_rem_reg <= blrd_pkg::PAD_W'(1));

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (cfg_ctl.restart || take_roll)
        begin
            phase_next = blrd_pkg::PH_HEADER;
        end
        else if (take_byte)
        begin
            unique case (phase_reg)
                blrd_pkg::PH_HEADER:
                begin
                    if (pad_skip)
                    begin
                        phase_next = (left_m1 != '0) ? blrd_pkg::PH_PADDING
                                                     : blrd_pkg::PH_HEADER;
                    end
                    else if (hdr_last)
                    begin
                        phase_next = hdr_err ? blrd_pkg::PH_HALTED : blrd_pkg::PH_PAYLOAD;
                    end
                end
                blrd_pkg::PH_PAYLOAD:
                begin
                    if (pay_end)
                    begin
                        phase_next = blrd_pkg::PH_HEADER;
                    end
                end
                blrd_pkg::PH_PADDING:
                begin
                    if (pad_end)
                    begin
                        phase_next = blrd_pkg::PH_HEADER;
                    end
                end
                blrd_pkg::PH_HALTED:
                begin
                    phase_next = blrd_pkg::PH_HALTED;
                end
                default:
                begin
                    phase_next = blrd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // Counters and header fields.
    always_comb
    begin
        block_pos_next = block_pos_reg;
        file_pos_next  = file_pos_reg;
        cur_file_next  = cur_file_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        hdr_len_next   = hdr_len_reg;
        pay_rem_next   = pay_rem_reg;
        pad_rem_next   = pad_rem_reg;
        kind_next      = kind_reg;
        if (cfg_ctl.restart || take_roll)
        begin
            cur_file_next  = cfg_ctl.restart ? cfg_ctl.start_file : cur_file_reg + 1'b1;
            block_pos_next = '0;
            file_pos_next  = '0;
            hdr_cnt_next   = '0;
            hdr_len_next   = '0;
            pay_rem_next   = '0;
            pad_rem_next   = '0;
            kind_next      = blrd_pkg::FRAG_FULL;
        end
        else if (take_byte)
        begin
            block_pos_next = pos_adv;
            file_pos_next  = fpos_adv;
            case (phase_reg)
                blrd_pkg::PH_HEADER:
                begin
                    if (pad_skip)
                    begin
                        pad_rem_next = left_m1[blrd_pkg::PAD_W-1:0];
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 1'b1;
                        case (hdr_cnt_reg)
                            blrd_pkg::HDR_CNT_W'(0):
                                hdr_len_next = {16'd0, log_stream.data_byte};
                            blrd_pkg::HDR_CNT_W'(1):
                                hdr_len_next[15:8] = log_stream.data_byte;
                            blrd_pkg::HDR_CNT_W'(2):
                                hdr_len_next[23:16] = log_stream.data_byte;
                            default:
                                ;
                        endcase
                        if (hdr_last)
                        begin
                            hdr_cnt_next = '0;
                            pay_rem_next = hdr_len_reg;
                            kind_next    = tclass.kind;
                        end
                    end
                end
                blrd_pkg::PH_PAYLOAD:
                begin
                    if (pay_rem_reg != '0)
                    begin
                        pay_rem_next = pay_rem_reg - 1'b1;
                    end
                end
                blrd_pkg::PH_PADDING:
                begin
                    if (pad_rem_reg != '0)
                    begin
                        pad_rem_next = pad_rem_reg - 1'b1;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    // Result of the accepted item.
    always_comb
    begin
        res_valid_next = res_valid_reg && !records.ready;
        res_byte_next  = res_byte_reg;
        res_kind_next  = res_kind_reg;
        res_fend_next  = res_fend_reg;
        res_mend_next  = res_mend_reg;
        res_file_next  = res_file_reg;
        res_off_next   = res_off_reg;
        res_st_next    = res_st_reg;
        if (take_eof || (take_byte && ((phase_reg == blrd_pkg::PH_PAYLOAD) ||
                                       (hdr_last && hdr_err))))
        begin
            res_valid_next = 1'b1;
            res_byte_next  = 8'd0;
            res_kind_next  = blrd_pkg::FRAG_FULL;
            res_fend_next  = 1'b0;
            res_mend_next  = 1'b0;
            res_file_next  = cur_file_reg;
            res_off_next   = '0;
            if (take_eof)
            begin
                res_st_next = blrd_pkg::ST_EOF;
            end
            else if (phase_reg == blrd_pkg::PH_PAYLOAD)
            begin
                res_st_next   = blrd_pkg::ST_PAYLOAD;
                res_byte_next = log_stream.data_byte;
                res_kind_next = kind_reg;
                res_fend_next = pay_end;
                res_mend_next = pay_end && ((kind_reg == blrd_pkg::FRAG_FULL) ||
                                            (kind_reg == blrd_pkg::FRAG_LAST));
                res_off_next  = pay_end ? fpos_adv : '0;
            end
            else
            begin
                res_st_next = err_st;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= blrd_pkg::PH_HEADER;
            block_pos_reg <= '0;
            file_pos_reg  <= '0;
            cur_file_reg  <= '0;
            hdr_cnt_reg   <= '0;
            hdr_len_reg   <= '0;
            pay_rem_reg   <= '0;
            pad_rem_reg   <= '0;
            kind_reg      <= blrd_pkg::FRAG_FULL;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            block_pos_reg <= block_pos_next;
            file_pos_reg  <= file_pos_next;
            cur_file_reg  <= cur_file_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            hdr_len_reg   <= hdr_len_next;
            pay_rem_reg   <= pay_rem_next;
            pad_rem_reg   <= pad_rem_next;
            kind_reg      <= kind_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        res_byte_reg <= res_byte_next;
        res_kind_reg <= res_kind_next;
        res_fend_reg <= res_fend_next;
        res_mend_reg <= res_mend_next;
        res_file_reg <= res_file_next;
        res_off_reg  <= res_off_next;
        res_st_reg   <= res_st_next;
    end

    assign records.valid             = res_valid_reg;
    assign records.payload_byte      = res_byte_reg;
    assign records.fragment_kind     = res_kind_reg;
    assign records.fragment_end      = res_fend_reg;
    assign records.message_end       = res_mend_reg;
    assign records.file_number       = res_file_reg;
    assign records.record_end_offset = res_off_reg;
    assign records.status            = res_st_reg;

endmodule

// ----- test/blrd_record_checker.sv -----
// Checker for the block log record deframer: predicts each record and compares it.
module blrd_record_checker
    import blrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    blrd_in_if                   log_stream,
    blrd_out_if                  records,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   failures,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // One record as it leaves the block.
    typedef struct packed {
        logic [7:0]        payload_byte;
        frag_t             fragment_kind;
        logic              fragment_end;
        logic              message_end;
        logic [FILE_W-1:0] file_number;
        logic [31:0]       record_end_offset;
        status_t           status;
    } log_record_t;

    log_record_t expected_records [$];

    // Shadow copy of the configuration registers.
    logic [FILE_W-1:0] start_file;
    logic [TYPE_W-1:0] code_zero;
    logic [TYPE_W-1:0] code_full;
    logic [TYPE_W-1:0] code_first;
    logic [TYPE_W-1:0] code_middle;
    logic [TYPE_W-1:0] code_last;

    // Shadow copy of the parser state.
    logic [16:0]       block_pos;
    logic [31:0]       file_pos;
    logic [FILE_W-1:0] cur_file;
    phase_t            phase;
    logic [2:0]        hdr_count;
    logic [LEN_W-1:0]  hdr_len;
    logic [TYPE_W-1:0] hdr_type;
    logic [LEN_W-1:0]  payload_left;
    logic [16:0]       padding_left;
    frag_t             cur_kind;

    int fail_count;
    int reported;

    // Start reading a file from offset zero.
    function automatic void restart_file(input logic [FILE_W-1:0] fnum);
        cur_file     = fnum;
        block_pos    = '0;
        file_pos     = '0;
        phase        = PH_HEADER;
        hdr_count    = '0;
        hdr_len      = '0;
        hdr_type     = '0;
        payload_left = '0;
        padding_left = '0;
        cur_kind     = FRAG_FULL;
    endfunction

    // Move both offsets past one file byte; the block offset wraps at the block size.
    function automatic void step_offsets();
        file_pos = file_pos + 32'd1;
        if (int'(block_pos) == BLOCK_BYTES - 1)
            block_pos = '0;
        else
            block_pos = block_pos + 17'd1;
    endfunction

    // A header problem is reported once and parsing halts.
    function automatic void halt_with(input status_t st, output log_record_t rec);
        rec             = '0;
        rec.file_number = cur_file;
        rec.status      = st;
        phase           = PH_HALTED;
    endfunction

    function automatic void apply_register(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_START_FILE:
            begin
                start_file = val;
                restart_file(val);
            end
            CFG_ZERO_TYPE:   code_zero   = val[TYPE_W-1:0];
            CFG_FULL_TYPE:   code_full   = val[TYPE_W-1:0];
            CFG_FIRST_TYPE:  code_first  = val[TYPE_W-1:0];
            CFG_MIDDLE_TYPE: code_middle = val[TYPE_W-1:0];
            CFG_LAST_TYPE:   code_last   = val[TYPE_W-1:0];
            default: ;
        endcase
    endfunction

    // Works out the record that one log item causes; returns 1 if there is one.
    function automatic bit predict_record(input action_t act, input logic [7:0] b,
                                          output log_record_t rec);
        int  left;
        int  space;
        bit  frag_done;
        rec = '0;
        rec.file_number = cur_file;
        if (act == ACT_ROLL)
        begin
            restart_file(cur_file + 32'd1);
            return 1'b0;
        end
        if (act == ACT_UNUSED || phase == PH_HALTED)
            return 1'b0;
        if (act == ACT_EOF)
        begin
            rec.status = ST_EOF;
            return 1'b1;
        end

        // Trailing bytes of a block are skipped without a record.
        if (phase == PH_PADDING)
        begin
            step_offsets();
            if (padding_left != 0)
                padding_left = padding_left - 17'd1;
            if (padding_left == 0)
                phase = PH_HEADER;
            return 1'b0;
        end

        // Payload bytes go out one by one with their end marks.
        if (phase == PH_PAYLOAD)
        begin
            step_offsets();
            if (payload_left != 0)
                payload_left = payload_left - 24'd1;
            frag_done             = (payload_left == 0);
            rec.payload_byte      = b;
            rec.fragment_kind     = cur_kind;
            rec.fragment_end      = frag_done;
            rec.message_end       = frag_done && (cur_kind == FRAG_FULL || cur_kind == FRAG_LAST);
            rec.record_end_offset = frag_done ? file_pos : 32'd0;
            rec.status            = ST_PAYLOAD;
            if (frag_done)
                phase = PH_HEADER;
            return 1'b1;
        end

        // Header phase: a header never starts in the last few bytes of a block.
        if (hdr_count == 0)
        begin
            left = BLOCK_BYTES - int'(block_pos);
            if (left <= HEADER_BYTES)
            begin
                step_offsets();
                padding_left = 17'(left - 1);
                if (padding_left != 0)
                    phase = PH_PADDING;
                return 1'b0;
            end
            hdr_len  = '0;
            hdr_type = '0;
        end
        if (hdr_count < 3)
            hdr_len[8*hdr_count +: 8] = b;
        if (int'(hdr_count) == HEADER_BYTES - 1)
            hdr_type = b;
        step_offsets();
        if (int'(hdr_count) != HEADER_BYTES - 1)
        begin
            hdr_count = hdr_count + 3'd1;
            return 1'b0;
        end
        hdr_count = '0;

        // Complete header: length check first, then the type codes by priority.
        space = BLOCK_BYTES - int'(block_pos);
        if (int'(hdr_len) > space)
        begin
            halt_with(ST_BAD, rec);
            return 1'b1;
        end
        if (hdr_type == code_zero || hdr_len == 0)
        begin
            halt_with(ST_OLD, rec);
            return 1'b1;
        end
        if (hdr_type == code_full)
            cur_kind = FRAG_FULL;
        else if (hdr_type == code_first)
            cur_kind = FRAG_FIRST;
        else if (hdr_type == code_middle)
            cur_kind = FRAG_MIDDLE;
        else if (hdr_type == code_last)
            cur_kind = FRAG_LAST;
        else
        begin
            halt_with(ST_UNKNOWN, rec);
            return 1'b1;
        end
        payload_left = hdr_len;
        phase        = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic string describe(input log_record_t rec);
        return $sformatf("byte %02h kind %0d fend %0b mend %0b file %08h offset %08h status %0d",
                         rec.payload_byte, rec.fragment_kind, rec.fragment_end,
                         rec.message_end, rec.file_number, rec.record_end_offset, rec.status);
    endfunction

    // Watch configuration writes and both channels on every clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        log_record_t want;
        log_record_t got;
        if (!rst_n)
        begin
            start_file  = '0;
            code_zero   = 8'd0;
            code_full   = 8'd1;
            code_first  = 8'd2;
            code_middle = 8'd3;
            code_last   = 8'd4;
            restart_file(start_file);
            expected_records.delete();
            fail_count  = 0;
            reported    = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
                apply_register(cfg_idx_t'(cfg_index), cfg_data);

            // Input transfer: predict and queue the record it causes.
            if (log_stream.valid && log_stream.ready)
            begin
                if (predict_record(action_t'(log_stream.action), log_stream.data_byte, want))
                    expected_records.push_back(want);
            end

            // Output transfer: compare against the oldest queued record.
            if (records.valid && records.ready)
            begin
                got.payload_byte      = records.payload_byte;
                got.fragment_kind     = frag_t'(records.fragment_kind);
                got.fragment_end      = records.fragment_end;
                got.message_end       = records.message_end;
                got.file_number       = records.file_number;
                got.record_end_offset = records.record_end_offset;
                got.status            = status_t'(records.status);
                if (expected_records.size() == 0)
                begin
                    fail_count++;
                    if (reported < REPORT_LIMIT)
                    begin
                        reported++;
                        $display("%0t: record with none expected: %s", $time, describe(got));
                    end
                end
                else
                begin
                    want = expected_records.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (reported < REPORT_LIMIT)
                        begin
                            reported++;
                            $display("%0t: record mismatch", $time);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(got));
                        end
                    end
                end
            end
            failures    <= fail_count;
            outstanding <= expected_records.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
// Top of the deframer testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import blrd_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PERCENT  = 14;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   failures;
    int                   outstanding;

    blrd_in_if  log_if ();
    blrd_out_if rec_if ();

    // Stimulus bookkeeping shared by the sender and receiver processes.
    bit          quiet_run;
    bit          hold_off_req;
    int unsigned items_sent;
    int unsigned cycle_count;
    logic [7:0]  type_code [6];

    block_log_record_deframer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .log_stream (log_if),
        .records    (rec_if),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    blrd_record_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .log_stream  (log_if),
        .records     (rec_if),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run-length guard.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off once it is requested.
    initial
    begin
        int unsigned hold_count;
        bit          hold_done;
        hold_done = 1'b0;
        rec_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                rec_if.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge clk);
            end
            else
                rec_if.ready <= quiet_run || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offer one log item, with random idle cycles first, and wait for its transfer.
    task automatic push_log(input action_t act, input logic [7:0] b);
        while (!quiet_run && $urandom_range(99) < IDLE_PERCENT)
        begin
            log_if.valid <= 1'b0;
            @(posedge clk);
        end
        log_if.valid     <= 1'b1;
        log_if.action    <= act;
        log_if.data_byte <= b;
        do
            @(posedge clk);
        while (!log_if.ready);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    // Header: 24-bit little-endian length, four filler bytes, then the type byte.
    task automatic push_header(input logic [23:0] len, input logic [7:0] code);
        int i;
        push_log(ACT_BYTE, len[7:0]);
        push_log(ACT_BYTE, len[15:8]);
        push_log(ACT_BYTE, len[23:16]);
        for (i = 3; i < HEADER_BYTES - 1; i++)
            push_log(ACT_BYTE, 8'($urandom));
        push_log(ACT_BYTE, code);
    endtask

    // Header plus body bytes; a short body leaves the record cut off.
    task automatic push_record(input logic [23:0] len, input logic [7:0] code,
                               input int unsigned body);
        int unsigned i;
        int unsigned r;
        push_header(len, code);
        for (i = 0; i < body; i++)
        begin
            r = $urandom_range(199);
            if (r < 3)
                push_log(ACT_EOF, 8'($urandom));
            else if (r < 5)
                push_log(ACT_UNUSED, 8'($urandom));
            push_log(ACT_BYTE, 8'($urandom));
        end
    endtask

    // Mostly short fragments, now and then a longer one.
    function automatic logic [23:0] pick_len();
        if ($urandom_range(9) == 0)
            return 24'($urandom_range(200, 13));
        return 24'($urandom_range(12, 1));
    endfunction

    // Stop offering, wait until every record is out, then let the pipeline settle.
    task automatic settle_idle();
        log_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        settle_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx != CFG_START_FILE)
            type_code[idx] = val[7:0];
    endtask

    // Random traffic: well-formed messages mostly, some noise and broken records.
    task automatic run_random(input int unsigned n);
        int unsigned stop_at;
        int unsigned r;
        int unsigned k;
        int unsigned i;
        logic [23:0] len;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                len = pick_len();
                push_record(len, type_code[CFG_FULL_TYPE], len);
            end
            else if (r < 70)
            begin
                len = pick_len();
                push_record(len, type_code[CFG_FIRST_TYPE], len);
                k = $urandom_range(3);
                for (i = 0; i < k; i++)
                begin
                    len = pick_len();
                    push_record(len, type_code[CFG_MIDDLE_TYPE], len);
                end
                len = pick_len();
                push_record(len, type_code[CFG_LAST_TYPE], len);
            end
            else if (r < 78)
                push_log(ACT_EOF, 8'($urandom));
            else if (r < 84)
                push_log(ACT_UNUSED, 8'($urandom));
            else if (r < 94)
            begin
                // Broken header, a few items that the halted block ignores, then a roll.
                case ($urandom_range(3))
                    0: push_header(24'd0, type_code[CFG_FULL_TYPE]);
                    1: push_header(pick_len(), type_code[CFG_ZERO_TYPE]);
                    2: push_header(pick_len(), 8'($urandom));
                    default: push_header(24'($urandom_range(24'hFFFFFF, 24'h010000)),
                                         type_code[CFG_FULL_TYPE]);
                endcase
                k = $urandom_range(3);
                for (i = 0; i < k; i++)
                    push_log(action_t'($urandom_range(1)), 8'($urandom));
                push_log(ACT_ROLL, 8'($urandom));
            end
            else
            begin
                // Record cut off by a roll to the next file.
                len = pick_len() + 24'd1;
                push_record(len, type_code[CFG_FULL_TYPE], $urandom_range(int'(len) - 1));
                push_log(ACT_ROLL, 8'($urandom));
            end
        end
    endtask

    // Main stimulus.
    initial
    begin
        int i;
        quiet_run    = 1'b0;
        hold_off_req = 1'b0;
        items_sent   = 0;
        type_code[CFG_START_FILE]  = 8'd0;
        type_code[CFG_ZERO_TYPE]   = 8'd0;
        type_code[CFG_FULL_TYPE]   = 8'd1;
        type_code[CFG_FIRST_TYPE]  = 8'd2;
        type_code[CFG_MIDDLE_TYPE] = 8'd3;
        type_code[CFG_LAST_TYPE]   = 8'd4;
        rst_n            <= 1'b0;
        log_if.valid     <= 1'b0;
        log_if.action    <= ACT_BYTE;
        log_if.data_byte <= 8'h00;
        cfg_write        <= 1'b0;
        cfg_index        <= CFG_START_FILE;
        cfg_data         <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks with the reset codes.
        push_log(ACT_EOF, 8'h00);
        push_log(ACT_UNUSED, 8'hFF);
        push_header(24'd1, type_code[CFG_FULL_TYPE]);
        push_log(ACT_BYTE, 8'h00);
        push_header(24'd3, type_code[CFG_FULL_TYPE]);
        push_log(ACT_BYTE, 8'hFF);
        push_log(ACT_BYTE, 8'hA5);
        push_log(ACT_BYTE, 8'h5A);
        push_record(24'd2, type_code[CFG_FIRST_TYPE], 2);
        push_record(24'd1, type_code[CFG_MIDDLE_TYPE], 1);
        push_record(24'd2, type_code[CFG_LAST_TYPE], 2);
        push_header(24'd2, type_code[CFG_FULL_TYPE]);
        push_log(ACT_EOF, 8'h00);
        push_log(ACT_BYTE, 8'h3C);
        push_log(ACT_EOF, 8'h00);
        push_log(ACT_BYTE, 8'hC3);

        // Zero length halts; the halted block ignores bytes and end of file.
        push_header(24'd0, type_code[CFG_FULL_TYPE]);
        push_log(ACT_BYTE, 8'h77);
        push_log(ACT_EOF, 8'h00);
        push_log(ACT_UNUSED, 8'h00);
        push_log(ACT_ROLL, 8'h00);
        push_header(24'd5, type_code[CFG_ZERO_TYPE]);
        push_log(ACT_ROLL, 8'h00);
        push_header(24'd4, 8'hFF);
        push_log(ACT_ROLL, 8'h00);
        push_header(24'hFFFFFF, type_code[CFG_FULL_TYPE]);
        push_log(ACT_ROLL, 8'h00);

        // Block end: a record leaving exactly one header of padding.
        push_record(24'(BLOCK_BYTES - 2 * HEADER_BYTES), type_code[CFG_FULL_TYPE],
                    BLOCK_BYTES - 2 * HEADER_BYTES);
        for (i = 0; i < HEADER_BYTES; i++)
        begin
            if (i == 3)
                push_log(ACT_EOF, 8'h00);
            push_log(ACT_BYTE, 8'($urandom));
        end
        // A record ending one byte short of the block, then the lone byte skipped.
        push_record(24'(BLOCK_BYTES - HEADER_BYTES - 1), type_code[CFG_FULL_TYPE],
                    BLOCK_BYTES - HEADER_BYTES - 1);
        push_log(ACT_BYTE, 8'($urandom));
        // Length one over the space left in the block.
        push_header(24'(BLOCK_BYTES - HEADER_BYTES + 1), type_code[CFG_FULL_TYPE]);
        push_log(ACT_ROLL, 8'h00);

        // Extreme codes and the highest file number, which wraps on a roll.
        write_reg(CFG_START_FILE, 32'hFFFF_FFFF);
        write_reg(CFG_ZERO_TYPE, 32'hFF);
        write_reg(CFG_FULL_TYPE, 32'h00);
        write_reg(CFG_FIRST_TYPE, 32'h80);
        write_reg(CFG_MIDDLE_TYPE, 32'h7F);
        write_reg(CFG_LAST_TYPE, 32'h01);
        push_record(24'd2, type_code[CFG_FULL_TYPE], 2);
        push_log(ACT_ROLL, 8'h00);
        push_record(24'd1, type_code[CFG_LAST_TYPE], 1);
        hold_off_req = 1'b1;
        run_random(450);

        // Overlapping codes: zero beats full, first beats middle.
        write_reg(CFG_START_FILE, 32'h0);
        write_reg(CFG_ZERO_TYPE, 32'h20);
        write_reg(CFG_FULL_TYPE, 32'h20);
        write_reg(CFG_FIRST_TYPE, 32'h31);
        write_reg(CFG_MIDDLE_TYPE, 32'h31);
        write_reg(CFG_LAST_TYPE, 32'h42);
        push_header(24'd3, 8'h20);
        push_log(ACT_ROLL, 8'h00);
        push_record(24'd2, 8'h31, 2);
        push_record(24'd2, 8'h42, 2);
        write_reg(CFG_FULL_TYPE, 32'h55);
        quiet_run = 1'b1;
        run_random(300);
        quiet_run = 1'b0;
        run_random(150);

        // Random codes and file number.
        write_reg(CFG_START_FILE, $urandom);
        write_reg(CFG_ZERO_TYPE, $urandom_range(255));
        write_reg(CFG_FULL_TYPE, $urandom_range(255));
        write_reg(CFG_FIRST_TYPE, $urandom_range(255));
        write_reg(CFG_MIDDLE_TYPE, $urandom_range(255));
        write_reg(CFG_LAST_TYPE, $urandom_range(255));
        run_random(450);

        // Back to the reset codes.
        write_reg(CFG_START_FILE, $urandom);
        write_reg(CFG_ZERO_TYPE, 32'd0);
        write_reg(CFG_FULL_TYPE, 32'd1);
        write_reg(CFG_FIRST_TYPE, 32'd2);
        write_reg(CFG_MIDDLE_TYPE, 32'd3);
        write_reg(CFG_LAST_TYPE, 32'd4);
        run_random(400);

        settle_idle();
        if (failures == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
